// File: src/sha1_pkg.sv
`default_nettype none

package sha1_pkg;

	localparam int unsigned DigestWords = 5;
	localparam int unsigned WindowWords = 16;
	localparam int unsigned RoundCount  = 80;
	localparam int unsigned GroupRounds = 20;

	localparam logic [7:0] PadByte  = 8'h80;
	localparam logic [5:0] LenFill  = 6'd56;
	localparam logic [5:0] LastFill = 6'd63;
	localparam logic [2:0] LastIdx  = 3'(DigestWords - 1);
	localparam logic [2:0] LastLen  = 3'd7;
	localparam logic [6:0] LastRnd  = 7'(RoundCount - 1);

	typedef logic [31:0] word_t;

	// source of the byte pushed into the block buffer
	typedef enum logic [1:0] {
		SEL_DATA,
		SEL_PAD,
		SEL_ZERO,
		SEL_LEN
	} byte_sel_t;

	typedef struct packed {
		logic      absorb;
		byte_sel_t byte_sel;
		logic [2:0] len_idx;
		logic      count_byte;
		logic      load_work;
		logic      round;
		logic [1:0] grp;
		logic      add_chain;
		logic      restart;
		logic [2:0] out_idx;
	} sha1_cmd_t;

	typedef struct packed {
		logic fill_full;
		logic fill_len;
	} sha1_stat_t;

	function automatic word_t init_word(input logic [2:0] idx);
		word_t w;
		case (idx)
			3'd0:    w = 32'h67452301;
			3'd1:    w = 32'hEFCDAB89;
			3'd2:    w = 32'h98BADCFE;
			3'd3:    w = 32'h10325476;
			default: w = 32'hC3D2E1F0;
		endcase
		return w;
	endfunction

	function automatic word_t round_key(input logic [1:0] grp);
		word_t k;
		case (grp)
			2'd0:    k = 32'h5A827999;
			2'd1:    k = 32'h6ED9EBA1;
			2'd2:    k = 32'h8F1BBCDC;
			default: k = 32'hCA62C1D6;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

// File: src/sha1_byte_if.sv
`default_nettype none

interface sha1_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       message_end;

	modport source (output valid, output data_byte, output byte_valid,
		output message_end, input ready);
	modport sink (input valid, input data_byte, input byte_valid,
		input message_end, output ready);
endinterface

`default_nettype wire

// File: src/sha1_digest_if.sv
`default_nettype none

interface sha1_digest_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index,
		output last_word, input ready);
	modport sink (input valid, input digest_word, input word_index,
		input last_word, output ready);
endinterface

`default_nettype wire

// File: src/sha1_datapath.sv
`default_nettype none

module sha1_datapath
	import sha1_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] data_byte,
	input  wire sha1_cmd_t  cmd,
	output sha1_stat_t      stat,
	output word_t           digest_word
);

	word_t       h_q [DigestWords];
	word_t       w_q [WindowWords];
	logic [23:0] acc_q;
	logic [63:0] bit_cnt_q;
	logic [5:0]  fill_q;
	word_t       a_q, b_q, c_q, d_q, e_q;

	logic [7:0]  in_byte;
	logic [63:0] len_shift;
	word_t       f_val;
	word_t       t_val;
	word_t       sched_new;
	word_t       push_word;

	assign len_shift = bit_cnt_q << {cmd.len_idx, 3'b000};

	always_comb begin
		case (cmd.byte_sel)
			SEL_DATA: in_byte = data_byte;
			SEL_PAD:  in_byte = PadByte;
			SEL_ZERO: in_byte = '0;
			default:  in_byte = len_shift[63:56];
		endcase
	end

	assign push_word = {acc_q, in_byte};

	always_comb begin
		case (cmd.grp)
			2'd0:    f_val = (b_q & c_q) | (~b_q & d_q);
			2'd2:    f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			default: f_val = b_q ^ c_q ^ d_q;
		endcase
	end

	assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + w_q[0] + round_key(cmd.grp);

	// schedule word sixteen rounds ahead of the one being used
	assign sched_new = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DigestWords; i++) begin
				h_q[i] <= init_word(3'(i));
			end
			bit_cnt_q <= '0;
			fill_q    <= '0;
		end else begin
			if (cmd.restart) begin
				for (int i = 0; i < DigestWords; i++) begin
					h_q[i] <= init_word(3'(i));
				end
				bit_cnt_q <= '0;
				fill_q    <= '0;
			end else begin
				if (cmd.add_chain) begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
				end
				if (cmd.count_byte) begin
					bit_cnt_q <= bit_cnt_q + 64'd8;
				end
				if (cmd.absorb) begin
					fill_q <= fill_q + 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.absorb) begin
			acc_q <= {acc_q[15:0], in_byte};
			if (fill_q[1:0] == 2'b11) begin
				for (int i = 0; i < WindowWords - 1; i++) begin
					w_q[i] <= w_q[i + 1];
				end
				w_q[WindowWords - 1] <= push_word;
			end
		end else if (cmd.round) begin
			for (int i = 0; i < WindowWords - 1; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[WindowWords - 1] <= {sched_new[30:0], sched_new[31]};
		end

		if (cmd.load_work) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (cmd.round) begin
			a_q <= t_val;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	assign stat.fill_full = (fill_q == LastFill);
	assign stat.fill_len  = (fill_q == LenFill);

	assign digest_word = (cmd.out_idx <= LastIdx) ? h_q[cmd.out_idx] : h_q[0];

`ifndef SYNTHESIS
	// a compression starts only on the byte that completes a block
	a_load_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_work |-> (fill_q == LastFill))
		else $error("compression started on a partial block");

	// bit count moves only with data bytes
	a_count_src: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.count_byte |-> (cmd.absorb && cmd.byte_sel == SEL_DATA))
		else $error("bit count advanced without a data byte");

	a_pad_len: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.absorb && cmd.byte_sel == SEL_LEN && cmd.len_idx == 3'd0) |-> stat.fill_len)
		else $error("length field not at offset 56");
`endif

endmodule

`default_nettype wire

// File: src/sha1_ctrl.sv
`default_nettype none

module sha1_ctrl
	import sha1_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_byte_valid,
	input  wire logic       in_message_end,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire sha1_stat_t stat,
	output sha1_cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_PAD_ONE,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_OUT
	} state_t;

	state_t     state_q, ret_q;
	logic [6:0] rnd_q;
	logic [2:0] len_q;
	logic [2:0] out_q;

	logic in_take;
	logic out_take;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign in_take   = in_valid && in_ready;
	assign out_take  = out_valid && out_ready;

	always_comb begin
		cmd            = '0;
		cmd.byte_sel   = SEL_DATA;
		cmd.len_idx    = len_q;
		cmd.out_idx    = out_q;
		if (rnd_q < 7'(GroupRounds)) begin
			cmd.grp = 2'd0;
		end else if (rnd_q < 7'(2 * GroupRounds)) begin
			cmd.grp = 2'd1;
		end else if (rnd_q < 7'(3 * GroupRounds)) begin
			cmd.grp = 2'd2;
		end else begin
			cmd.grp = 2'd3;
		end
		unique case (state_q)
			ST_IDLE: begin
				cmd.absorb     = in_take && in_byte_valid;
				cmd.count_byte = in_take && in_byte_valid;
				cmd.load_work  = in_take && in_byte_valid && stat.fill_full;
			end
			ST_ROUND: cmd.round = 1'b1;
			ST_ADD:   cmd.add_chain = 1'b1;
			ST_PAD_ONE: begin
				cmd.absorb    = 1'b1;
				cmd.byte_sel  = SEL_PAD;
				cmd.load_work = stat.fill_full;
			end
			ST_PAD_ZERO: begin
				cmd.absorb    = !stat.fill_len;
				cmd.byte_sel  = SEL_ZERO;
				cmd.load_work = !stat.fill_len && stat.fill_full;
			end
			ST_PAD_LEN: begin
				cmd.absorb    = 1'b1;
				cmd.byte_sel  = SEL_LEN;
				cmd.load_work = stat.fill_full;
			end
			ST_OUT:   cmd.restart = out_take && (out_q == LastIdx);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			rnd_q   <= '0;
			len_q   <= '0;
			out_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						if (in_byte_valid && stat.fill_full) begin
							ret_q   <= in_message_end ? ST_PAD_ONE : ST_IDLE;
							rnd_q   <= '0;
							state_q <= ST_ROUND;
						end else if (in_message_end) begin
							state_q <= ST_PAD_ONE;
						end
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == LastRnd) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: state_q <= ret_q;
				ST_PAD_ONE: begin
					if (stat.fill_full) begin
						ret_q   <= ST_PAD_ZERO;
						rnd_q   <= '0;
						state_q <= ST_ROUND;
					end else begin
						state_q <= ST_PAD_ZERO;
					end
				end
				ST_PAD_ZERO: begin
					if (stat.fill_len) begin
						len_q   <= '0;
						state_q <= ST_PAD_LEN;
					end else if (stat.fill_full) begin
						ret_q   <= ST_PAD_ZERO;
						rnd_q   <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_PAD_LEN: begin
					len_q <= len_q + 3'd1;
					if (len_q == LastLen) begin
						ret_q   <= ST_OUT;
						out_q   <= '0;
						rnd_q   <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_OUT: begin
					if (out_take) begin
						out_q <= out_q + 3'd1;
						if (out_q == LastIdx) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (rnd_q <= LastRnd))
		else $error("round counter out of range");

	a_sides_apart: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while digest pending");

	a_digest_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && out_q == LastIdx) |=> (state_q == ST_IDLE && out_q == 3'd0 + 3'(DigestWords)))
		else $error("digest drain did not return to idle");

	a_add_after_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD) |-> ($past(state_q) == ST_ROUND && $past(rnd_q) == LastRnd))
		else $error("chain update without full round sequence");

	a_len_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAD_LEN && len_q == LastLen) |-> stat.fill_full)
		else $error("length field does not close the block");
`endif

endmodule

`default_nettype wire

// File: src/sha1_hash_engine_top.sv
`default_nettype none

// channel     | dir | beat payload                               | handshake
// byte_in     | in  | data_byte[7:0], byte_valid, message_end    | valid/ready
// digest_out  | out | digest_word[31:0], word_index[2:0], last   | valid/ready
//
// Flow: one input beat per cycle while buffering; the 64th byte of a block
//   stalls byte_in through the 80 rounds (one round a cycle) and the chain add.
// Message end: padding is fed one byte a cycle between compressions (0x80, zeros,
//   the 8-byte length) with one or two compressions, then five digest beats, h0 first.
// Reset: arst_n loads the SHA-1 initial value and clears bit and fill counts.
// Stalls: byte_in.ready is low from message end until the last digest beat is
//   taken; digest_out holds each word until ready.

module sha1_hash_engine_top
	import sha1_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	sha1_byte_if.sink    byte_in,
	sha1_digest_if.source digest_out
);

	sha1_cmd_t  cmd;
	sha1_stat_t stat;
	logic       in_ready;
	logic       out_valid;
	word_t      digest_word;

	// sequencer: block/pad/round/output control
	sha1_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (byte_in.valid),
		.in_byte_valid  (byte_in.byte_valid),
		.in_message_end (byte_in.message_end),
		.in_ready       (in_ready),
		.out_valid      (out_valid),
		.out_ready      (digest_out.ready),
		.stat           (stat),
		.cmd            (cmd)
	);

	// chain words, message window, working registers, counters
	sha1_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (byte_in.data_byte),
		.cmd         (cmd),
		.stat        (stat),
		.digest_word (digest_word)
	);

	assign byte_in.ready          = in_ready;
	assign digest_out.valid       = out_valid;
	assign digest_out.digest_word = digest_word;
	assign digest_out.word_index  = cmd.out_idx;
	assign digest_out.last_word   = (cmd.out_idx == LastIdx);

endmodule

`default_nettype wire
